@@ rtl/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// srt_pkg
// shared constants, types and control struct for the 16-bit ascending sorter
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic ins;
        logic shl;
    } t_cell_ctrl;

endpackage
// ----------------------------------------------------------------------------

@@ rtl/srt_cell.sv @@
// ----------------------------------------------------------------------------
// srt_cell
// one sorter cell: holds one element, takes the new value or the left
// neighbor's element on insert, takes the right neighbor's element on drain
// ----------------------------------------------------------------------------
module srt_cell (
    input  logic                       i_clk,
    input  srt_pkg::t_cell_ctrl        i_ctrl,
    input  logic                       i_occ,
    input  logic [srt_pkg::DATA_W-1:0] i_new,
    input  logic                       i_left_gt,
    input  logic [srt_pkg::DATA_W-1:0] i_left_val,
    input  logic [srt_pkg::DATA_W-1:0] i_right_val,
    output logic                       o_gt,
    output logic [srt_pkg::DATA_W-1:0] o_val
);

    logic [srt_pkg::DATA_W-1:0] r_val;
    logic [srt_pkg::DATA_W-1:0] n_val;

    // empty cells count as larger than anything
    assign o_gt  = !i_occ || (r_val > i_new);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.shl) begin
            n_val = i_right_val;
        end else if (i_ctrl.ins && o_gt) begin
            n_val = i_left_gt ? i_left_val : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
// ----------------------------------------------------------------------------

@@ rtl/sort_uint16_ascending_unit.sv @@
// ----------------------------------------------------------------------------
// sort_uint16_ascending_unit
// insertion sorter over a row of cells for sets of up to 64 unsigned values
// ----------------------------------------------------------------------------
// Values enter one beat per cycle while the unit is loading; each one is placed
// into its sorted slot in the cell row in the same cycle it is accepted.
// The beat with tlast closes the set, and input stalls while the set drains:
// the row shifts toward cell 0 once per accepted output beat. Values past 64
// are dropped and tuser is high on every output beat of that set. Equal
// values are all kept.
// ----------------------------------------------------------------------------
module sort_uint16_ascending_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // value
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // sorted_value
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser   // dropped
);

    localparam int CAP = srt_pkg::CAPACITY;
    localparam int DW  = srt_pkg::DATA_W;
    localparam int CW  = srt_pkg::CNT_W;

    srt_pkg::t_state     r_state;
    srt_pkg::t_state     n_state;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       n_cnt;
    logic                r_ovf;
    logic                n_ovf;
    srt_pkg::t_cell_ctrl ctrl;
    logic                s_hs;
    logic                m_hs;
    logic                full;
    logic                final_beat;
    logic [CAP-1:0]      gt;
    logic [DW-1:0]       val [CAP];

    assign s_hs       = i_s_axis_tvalid && o_s_axis_tready;
    assign m_hs       = o_m_axis_tvalid && i_m_axis_tready;
    assign full       = (r_cnt == CW'(CAP));
    assign final_beat = (r_cnt == CW'(1));
    assign ctrl.ins   = s_hs && !full;
    assign ctrl.shl   = m_hs;

    genvar g;
    generate
        for (g = 0; g < CAP; g++) begin : g_cell
            logic          occ;
            logic          left_gt;
            logic [DW-1:0] left_val;
            logic [DW-1:0] right_val;

            assign occ = (r_cnt > CW'(g));

            if (g == 0) begin : g_head
                assign left_gt  = 1'b0;
                assign left_val = '0;
            end else begin : g_body
                assign left_gt  = gt[g-1];
                assign left_val = val[g-1];
            end

            if (g == CAP - 1) begin : g_tail
                assign right_val = '0;
            end else begin : g_mid
                assign right_val = val[g+1];
            end

            srt_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_occ       (occ),
                .i_new       (i_s_axis_tdata),
                .i_left_gt   (left_gt),
                .i_left_val  (left_val),
                .i_right_val (right_val),
                .o_gt        (gt[g]),
                .o_val       (val[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            srt_pkg::ST_LOAD: begin
                if (s_hs && i_s_axis_tlast) begin
                    n_state = srt_pkg::ST_DRAIN;
                end
            end
            srt_pkg::ST_DRAIN: begin
                if (m_hs && final_beat) begin
                    n_state = srt_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = srt_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == srt_pkg::ST_LOAD);
        o_m_axis_tvalid = (r_state == srt_pkg::ST_DRAIN);
        o_m_axis_tdata  = val[0];
        o_m_axis_tlast  = final_beat;
        o_m_axis_tuser  = r_ovf;
    end

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (ctrl.ins) begin
            n_cnt = r_cnt + CW'(1);
        end else if (ctrl.shl) begin
            n_cnt = r_cnt - CW'(1);
        end
        if (s_hs && full) begin
            n_ovf = 1'b1;
        end else if (m_hs && final_beat) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srt_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

`ifndef SYNTH
    a_drain_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srt_pkg::ST_DRAIN) |-> (r_cnt != '0))
        else $error("draining an empty set");

    a_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAP))
        else $error("fill count beyond capacity");

    a_close_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_hs && o_m_axis_tlast) |=> (r_cnt == '0 && !r_ovf
            && r_state == srt_pkg::ST_LOAD))
        else $error("set not cleared after final beat");

    a_ascending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_hs && !o_m_axis_tlast) |=> ($past(o_m_axis_tdata) <= o_m_axis_tdata))
        else $error("output out of order");
`endif

endmodule
// ----------------------------------------------------------------------------

@@ bench/sort_checker.sv @@
// ----------------------------------------------------------------------------
// sort_checker
// watches both stream channels of the 16-bit ascending sorter and checks them
// ----------------------------------------------------------------------------
// Every accepted input beat is added to the set being collected. When the
// set closes on tlast, the held values are sorted and queued as the output
// beats that are due. Each accepted output beat is compared with the oldest
// due beat on value, tlast and the dropped flag in tuser.
// ----------------------------------------------------------------------------
module sort_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [srt_pkg::DATA_W-1:0] i_in_data,
    input  logic                       i_in_last,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [srt_pkg::DATA_W-1:0] i_out_data,
    input  logic                       i_out_last,
    input  logic                       i_out_dropped,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [srt_pkg::DATA_W-1:0] value;
        logic                       last;
        logic                       dropped;
    } t_sorted_beat;

    logic [srt_pkg::DATA_W-1:0] held [srt_pkg::CAPACITY];
    int                         held_count    = 0;
    logic                       held_overflow = 1'b0;
    t_sorted_beat               sorted_due [$];
    int                         err_count     = 0;
    int                         out_beats     = 0;

    always @(posedge i_clk) begin
        t_sorted_beat               due;
        logic [srt_pkg::DATA_W-1:0] swap;
        if (!i_rst_n) begin
            held_count    = 0;
            held_overflow = 1'b0;
            sorted_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sorted_due.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected output beat %0d: value %h last %b dropped %b",
                                 out_beats, i_out_data, i_out_last, i_out_dropped);
                end else begin
                    due = sorted_due.pop_front();
                    if (due.value !== i_out_data || due.last !== i_out_last ||
                        due.dropped !== i_out_dropped) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch beat %0d: exp %h/%b/%b got %h/%b/%b",
                                     out_beats, due.value, due.last, due.dropped,
                                     i_out_data, i_out_last, i_out_dropped);
                    end
                end
                out_beats++;
            end
            if (i_in_valid && i_in_ready) begin
                if (held_count < srt_pkg::CAPACITY) begin
                    held[held_count] = i_in_data;
                    held_count++;
                end else begin
                    held_overflow = 1'b1;
                end
                if (i_in_last) begin
                    for (int p = 0; p + 1 < held_count; p++) begin
                        for (int k = 0; k + 1 < held_count - p; k++) begin
                            if (held[k] > held[k + 1]) begin
                                swap        = held[k];
                                held[k]     = held[k + 1];
                                held[k + 1] = swap;
                            end
                        end
                    end
                    for (int k = 0; k < held_count; k++) begin
                        due.value   = held[k];
                        due.last    = (k + 1 == held_count);
                        due.dropped = held_overflow;
                        sorted_due.push_back(due);
                    end
                    held_count    = 0;
                    held_overflow = 1'b0;
                end
            end
        end
        o_pending    <= sorted_due.size();
        o_fail_count <= err_count;
    end

endmodule
// ----------------------------------------------------------------------------

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the 16-bit ascending sorter
// ----------------------------------------------------------------------------
// A short directed run covers the value extremes, equal values and reversed
// order, then random sets follow: mostly small ones, one exact-capacity set
// and one set that overflows, with its closing beat among the dropped ones.
// The sender runs in bursts with gaps, the receiver stalls in changing
// patterns and twice holds off long enough to stall the input. A checker
// beside the block predicts and compares; a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL    = 200;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;

    // last flag in bit 16, value below
    localparam logic [srt_pkg::DATA_W:0] DIRECTED_BEATS [0:20] = '{
        {1'b1, 16'h0000},
        {1'b1, 16'hFFFF},
        {1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b0, 16'h8000}, {1'b0, 16'h7FFF},
        {1'b0, 16'h0001}, {1'b0, 16'hFFFE}, {1'b0, 16'hAAAA}, {1'b1, 16'h5555},
        {1'b0, 16'h0003}, {1'b0, 16'h0003}, {1'b0, 16'h0001}, {1'b1, 16'h0003},
        {1'b0, 16'h0009}, {1'b0, 16'h0008}, {1'b0, 16'h0007}, {1'b0, 16'h0006},
        {1'b1, 16'h0005},
        {1'b0, 16'h0001}, {1'b1, 16'h0002}
    };

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [srt_pkg::DATA_W-1:0] s_tdata  = '0;   // value
    logic                       s_tlast  = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [srt_pkg::DATA_W-1:0] m_tdata;         // sorted_value
    logic                       m_tlast;
    logic                       m_tuser;         // dropped
    int                         fail_count;
    int                         pending;
    int                         items_sent   = 0;
    int                         burst_left   = 0;
    int                         hold_asks    = 0;
    int                         stall_cycles = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sort_uint16_ascending_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    sort_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (s_tvalid),
        .i_in_ready    (s_tready),
        .i_in_data     (s_tdata),
        .i_in_last     (s_tlast),
        .i_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .i_out_data    (m_tdata),
        .i_out_last    (m_tlast),
        .i_out_dropped (m_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic logic [srt_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 7));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_beat(input logic [srt_pkg::DATA_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // receiver: changing stall patterns, plus a long hold-off on request
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int hold_seen;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ~m_tready;
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int  set_idx;
        int  set_len;
        bit  dup_heavy;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < $size(DIRECTED_BEATS); k++)
            send_beat(DIRECTED_BEATS[k][srt_pkg::DATA_W-1:0],
                      DIRECTED_BEATS[k][srt_pkg::DATA_W]);

        set_idx = 0;
        while (items_sent < ITEM_GOAL) begin
            case (set_idx)
                1: begin
                    set_len = srt_pkg::CAPACITY + $urandom_range(1, 4);
                    hold_asks++;
                end
                3: begin
                    set_len = srt_pkg::CAPACITY;
                    hold_asks++;
                end
                default: set_len = $urandom_range(1, 12);
            endcase
            dup_heavy = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < set_len; k++)
                send_beat(dup_heavy ? 16'($urandom_range(0, 3)) : pick_value(),
                          k == set_len - 1);
            set_idx++;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
// ----------------------------------------------------------------------------

@@ filelist.f @@
rtl/srt_pkg.sv
rtl/srt_cell.sv
rtl/sort_uint16_ascending_unit.sv
bench/sort_checker.sv
bench/tb.sv
